// File: rtl/core/fctl_pkg.sv
package fctl_pkg;

    localparam int ADDR_W = 32;

    localparam logic [15:0] IPV4_TYPE       = 16'h0800;
    localparam logic [15:0] MIN_COUNTED_LEN = 16'd34;

    // Remainder unit for set counts that are not a power of two
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STEPS     = ADDR_W / DIV_STEP_BITS;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [31:0] dest_addr;
        logic [63:0] arrival_time;
    } t_fctl_req;

    typedef struct packed {
        logic        counted;
        logic        hit;
        logic        evicted;
        logic [63:0] packet_total;
        logic [63:0] byte_total;
    } t_fctl_rsp;

    typedef struct packed {
        logic [31:0] key;
        logic [63:0] packets;
        logic [63:0] bytes;
        logic [63:0] seen_stamp;
    } t_entry;

    typedef struct packed {
        logic hit;
        logic evict;
    } t_sel_flags;

endpackage

// File: rtl/core/flow_counter_table_lru.sv
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   i_in_req  (t_fctl_req)
// result    out        o_out_valid / i_out_stall o_out_rsp (t_fctl_rsp)
//
// One request in flight. A counted request passes through the set index step (a
// mask when the set count is a power of two, else the remainder unit), one
// synchronous read of the set and one write-back. A request that is not counted
// skips these and goes straight to the result register.
// After reset the metadata memory is swept, one set per cycle over all sets
// (2048 by default); requests are stalled during the sweep.
// A stalled result holds the block in its last step; the next request is taken
// as soon as the result register is loaded, while the result waits.
module flow_counter_table_lru
    import fctl_pkg::*;
#(
    parameter int ENTRY_COUNT = 8192,
    parameter int WAYS        = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_fctl_req i_in_req,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_fctl_rsp o_out_rsp
);

    localparam int SetCount = (ENTRY_COUNT / WAYS > 0) ? ENTRY_COUNT / WAYS : 1;
    localparam int SetW     = (SetCount > 1) ? $clog2(SetCount) : 1;
    localparam int RankW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MetaW    = WAYS + WAYS * RankW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INDEX,
        S_EVAL
    } t_state;

    t_state            r_state;
    t_fctl_req         r_req;
    logic              r_counted;
    logic [SetW-1:0]   r_set;
    logic              r_out_valid;
    t_fctl_rsp         r_out_rsp;

    logic              in_take;
    logic              counted_in;
    logic              idx_done;
    logic [SetW-1:0]   idx_set;
    logic              rd_en;
    logic              wr_en;
    logic              eval_go;
    logic              meta_busy;
    logic [MetaW-1:0]  meta_rd;
    logic [MetaW-1:0]  meta_wr;
    t_entry [WAYS-1:0] row_rd;
    t_entry [WAYS-1:0] row_wr;
    logic [WAYS-1:0]   way_sel;
    t_sel_flags        sel_flags;
    logic [63:0]       packet_total;
    logic [63:0]       byte_total;
    t_fctl_rsp         rsp_next;

    assign counted_in = (i_in_req.ether_type == IPV4_TYPE)
                     && (i_in_req.frame_length >= MIN_COUNTED_LEN);
    assign o_in_stall = (r_state != S_IDLE) || meta_busy;
    assign in_take    = i_in_valid && !o_in_stall;
    assign eval_go    = (r_state == S_EVAL) && (!r_out_valid || !i_out_stall);
    assign rd_en      = (r_state == S_INDEX) && idx_done;
    // write-back lands before the next request can read, so no forwarding
    assign wr_en      = eval_go && r_counted;

    fctl_set_index #(
        .SET_COUNT (SetCount)
    ) u_set_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_take && counted_in),
        .i_addr  (i_in_req.dest_addr),
        .o_done  (idx_done),
        .o_set   (idx_set)
    );

    fctl_meta_store #(
        .SET_COUNT (SetCount),
        .WAYS      (WAYS)
    ) u_meta_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx_set),
        .o_rd_data (meta_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_set),
        .i_wr_data (meta_wr),
        .o_busy    (meta_busy)
    );

    fctl_entry_store #(
        .SET_COUNT (SetCount),
        .WAYS      (WAYS)
    ) u_entry_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx_set),
        .o_rd_data (row_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_set),
        .i_wr_data (row_wr)
    );

    fctl_way_logic #(
        .WAYS (WAYS)
    ) u_way_logic (
        .i_meta         (meta_rd),
        .i_row          (row_rd),
        .i_req          (r_req),
        .o_meta         (meta_wr),
        .o_row          (row_wr),
        .o_sel          (way_sel),
        .o_flags        (sel_flags),
        .o_packet_total (packet_total),
        .o_byte_total   (byte_total)
    );

    always_comb begin
        rsp_next = '0;
        if (r_counted) begin
            rsp_next.counted      = 1'b1;
            rsp_next.hit          = sel_flags.hit;
            rsp_next.evicted      = sel_flags.evict;
            rsp_next.packet_total = packet_total;
            rsp_next.byte_total   = byte_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= counted_in ? S_INDEX : S_EVAL;
                    end
                end
                S_INDEX: begin
                    if (idx_done) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (eval_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (eval_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_take) begin
            r_req     <= i_in_req;
            r_counted <= counted_in;
        end
        if (rd_en) begin
            r_set <= idx_set;
        end
        if (eval_go) begin
            r_out_rsp <= rsp_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    a_one_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_counted) |-> $onehot(way_sel))
        else $error("way choice is not a single way");

    a_install_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.counted && !o_out_rsp.hit)
            |-> (o_out_rsp.packet_total == 64'd1))
        else $error("new entry does not start at one packet");

    a_evict_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.evicted) |-> (o_out_rsp.counted && !o_out_rsp.hit))
        else $error("eviction reported on a hit or an uncounted frame");

    a_sweep_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        meta_busy |-> (r_state == S_IDLE && !r_out_valid))
        else $error("request in flight during metadata sweep");

endmodule

// File: rtl/core/fctl_set_index.sv
module fctl_set_index
    import fctl_pkg::*;
#(
    parameter int SET_COUNT = 2048,
    localparam int SetW = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_done,
    output logic [SetW-1:0]   o_set
);

    localparam bit SetPow2 = (SET_COUNT & (SET_COUNT - 1)) == 0;

    if (SetPow2) begin : g_mask
        logic            r_done;
        logic [SetW-1:0] r_set;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
            if (i_start) begin
                r_set <= SetW'(i_addr & ADDR_W'(SET_COUNT - 1));
            end
        end

        assign o_done = r_done;
        assign o_set  = r_set;
    end else begin : g_divide
        localparam int CntW = $clog2(DIV_STEPS);

        logic              r_busy;
        logic              r_done;
        logic [CntW-1:0]   r_cnt;
        logic [ADDR_W-1:0] r_shift;
        logic [SetW-1:0]   r_rem;
        logic [SetW-1:0]   n_rem;
        logic [SetW:0]     step_val;

        // restoring remainder, a few address bits per cycle, msb first
        always_comb begin
            n_rem    = r_rem;
            step_val = '0;
            for (int k = 0; k < DIV_STEP_BITS; k++) begin
                step_val = {n_rem, r_shift[ADDR_W-1-k]};
                if (step_val >= (SetW+1)'(SET_COUNT)) begin
                    step_val = step_val - (SetW+1)'(SET_COUNT);
                end
                n_rem = step_val[SetW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_done <= 1'b0;
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end else if (r_busy) begin
                    if (r_cnt == CntW'(DIV_STEPS - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_start) begin
                r_shift <= i_addr;
                r_rem   <= '0;
            end else if (r_busy) begin
                r_shift <= r_shift << DIV_STEP_BITS;
                r_rem   <= n_rem;
            end
        end

        assign o_done = r_done;
        assign o_set  = r_rem;
    end

endmodule

// File: rtl/core/fctl_meta_store.sv
module fctl_meta_store
    import fctl_pkg::*;
#(
    parameter int SET_COUNT = 2048,
    parameter int WAYS      = 4,
    localparam int SetW  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1,
    localparam int RankW = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int MetaW = WAYS + WAYS * RankW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [SetW-1:0]  i_rd_addr,
    output logic [MetaW-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [SetW-1:0]  i_wr_addr,
    input  logic [MetaW-1:0] i_wr_data,
    output logic             o_busy
);

    // row layout: {valid[WAYS-1:0], rank[WAYS-1] .. rank[0]}
    logic [MetaW-1:0] r_mem [SET_COUNT];
    logic [MetaW-1:0] r_rd_data;
    logic             r_clr_active;
    logic [SetW-1:0]  r_clr_addr;
    logic [MetaW-1:0] reset_row;

    always_comb begin
        reset_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            reset_row[w*RankW +: RankW] = RankW'(w);
        end
    end

    // sweep every set once after reset: all ways invalid, identity ranking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == SetW'(SET_COUNT - 1)) begin
                r_clr_active <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_addr] <= reset_row;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_active;

endmodule

// File: rtl/core/fctl_entry_store.sv
module fctl_entry_store
    import fctl_pkg::*;
#(
    parameter int SET_COUNT = 2048,
    parameter int WAYS      = 4,
    localparam int SetW = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [SetW-1:0]       i_rd_addr,
    output t_entry [WAYS-1:0]     o_rd_data,
    input  logic                  i_wr_en,
    input  logic [SetW-1:0]       i_wr_addr,
    input  t_entry [WAYS-1:0]     i_wr_data
);

    t_entry [WAYS-1:0] r_mem [SET_COUNT];
    t_entry [WAYS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/fctl_way_logic.sv
module fctl_way_logic
    import fctl_pkg::*;
#(
    parameter int WAYS = 4,
    localparam int RankW = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int MetaW = WAYS + WAYS * RankW
) (
    input  logic [MetaW-1:0]  i_meta,
    input  t_entry [WAYS-1:0] i_row,
    input  t_fctl_req         i_req,
    output logic [MetaW-1:0]  o_meta,
    output t_entry [WAYS-1:0] o_row,
    output logic [WAYS-1:0]   o_sel,
    output t_sel_flags        o_flags,
    output logic [63:0]       o_packet_total,
    output logic [63:0]       o_byte_total
);

    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            hit_vec;
    logic [WAYS-1:0]            hit_first;
    logic [WAYS-1:0]            free_first;
    logic [WAYS-1:0]            lru_vec;
    logic [WAYS-1:0]            sel;
    logic [WAYS-1:0]            upd_valid;
    logic [WAYS-1:0][RankW-1:0] ranks;
    logic [WAYS-1:0][RankW-1:0] upd_ranks;
    logic [RankW-1:0]           sel_rank;
    logic                       hit_taken;
    logic                       free_taken;
    t_entry                     sel_old;
    t_entry                     sel_new;

    always_comb begin
        valid      = i_meta[MetaW-1 -: WAYS];
        ranks      = i_meta[WAYS*RankW-1:0];
        hit_taken  = 1'b0;
        free_taken = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w]    = valid[w] && (i_row[w].key == i_req.dest_addr);
            hit_first[w]  = hit_vec[w] && !hit_taken;
            hit_taken     = hit_taken | hit_vec[w];
            free_first[w] = !valid[w] && !free_taken;
            free_taken    = free_taken | !valid[w];
            lru_vec[w]    = ranks[w] == RankW'(WAYS - 1);
        end

        // hit way, else lowest free way, else least recent way
        if (hit_taken) begin
            sel = hit_first;
        end else if (free_taken) begin
            sel = free_first;
        end else begin
            sel = lru_vec;
        end

        sel_rank = '0;
        sel_old  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (sel[w]) begin
                sel_rank = ranks[w];
                sel_old  = i_row[w];
            end
        end

        if (hit_taken) begin
            sel_new.key     = sel_old.key;
            sel_new.packets = sel_old.packets + 64'd1;
            sel_new.bytes   = sel_old.bytes + 64'(i_req.frame_length);
        end else begin
            sel_new.key     = i_req.dest_addr;
            sel_new.packets = 64'd1;
            sel_new.bytes   = 64'(i_req.frame_length);
        end
        sel_new.seen_stamp = i_req.arrival_time;

        for (int w = 0; w < WAYS; w++) begin
            o_row[w] = sel[w] ? sel_new : i_row[w];
            if (sel[w]) begin
                upd_ranks[w] = '0;
            end else if (ranks[w] < sel_rank) begin
                upd_ranks[w] = ranks[w] + 1'b1;
            end else begin
                upd_ranks[w] = ranks[w];
            end
        end
        upd_valid = valid | sel;
    end

    assign o_meta         = {upd_valid, upd_ranks};
    assign o_sel          = sel;
    assign o_flags.hit    = hit_taken;
    assign o_flags.evict  = !hit_taken && !free_taken;
    assign o_packet_total = sel_new.packets;
    assign o_byte_total   = sel_new.bytes;

endmodule

// File: dv/tb_flow_counter_table_lru.sv
`timescale 1ns / 1ps

module tb_flow_counter_table_lru;
    import fctl_pkg::*;

    localparam int ENTRY_COUNT  = 8192;
    localparam int WAY_COUNT    = 4;
    localparam int SET_COUNT    = ENTRY_COUNT / WAY_COUNT;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 530;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOT_SETS     = 6;
    localparam int POOL_DEPTH   = 7;
    localparam int DIR_SET      = 5;

    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    // Mirrors the flow table: per-set ways with true LRU ranks, plus the
    // queue of results still owed by the block.
    class flow_stats_board #(int SETS = 2048, int NWAYS = 4);
        bit          slot_valid [SETS][NWAYS];
        logic [31:0] slot_key   [SETS][NWAYS];
        logic [63:0] slot_pkts  [SETS][NWAYS];
        logic [63:0] slot_bytes [SETS][NWAYS];
        logic [63:0] slot_seen  [SETS][NWAYS];
        int unsigned slot_rank  [SETS][NWAYS];
        t_fctl_rsp   owed_q [$];
        int          errors;
        int          n_requests;
        int          n_counted;
        int          n_hits;
        int          n_evicts;
        int          n_checked;

        function new();
            for (int s = 0; s < SETS; s++) begin
                for (int w = 0; w < NWAYS; w++) begin
                    slot_valid[s][w] = 1'b0;
                    slot_rank[s][w]  = w;
                end
            end
            errors     = 0;
            n_requests = 0;
            n_counted  = 0;
            n_hits     = 0;
            n_evicts   = 0;
            n_checked  = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_request(t_fctl_req r);
            t_fctl_rsp   rsp;
            int unsigned set_idx;
            int          way;
            bit          found;
            bit          evict;
            int unsigned old_rank;
            rsp   = '0;
            way   = -1;
            found = 1'b0;
            evict = 1'b0;
            n_requests++;
            if (r.frame_length >= MIN_COUNTED_LEN && r.ether_type == IPV4_TYPE) begin
                set_idx = r.dest_addr % SETS;
                for (int w = 0; w < NWAYS; w++) begin
                    if (way < 0 && slot_valid[set_idx][w]
                            && slot_key[set_idx][w] == r.dest_addr) begin
                        way   = w;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    slot_pkts[set_idx][way]  += 64'd1;
                    slot_bytes[set_idx][way] += r.frame_length;
                    slot_seen[set_idx][way]   = r.arrival_time;
                end else begin
                    for (int w = 0; w < NWAYS; w++) begin
                        if (way < 0 && !slot_valid[set_idx][w])
                            way = w;
                    end
                    if (way < 0) begin
                        for (int w = 0; w < NWAYS; w++) begin
                            if (slot_rank[set_idx][w] == NWAYS - 1)
                                way = w;
                        end
                        evict = 1'b1;
                    end
                    slot_valid[set_idx][way] = 1'b1;
                    slot_key[set_idx][way]   = r.dest_addr;
                    slot_pkts[set_idx][way]  = 64'd1;
                    slot_bytes[set_idx][way] = 64'(r.frame_length);
                    slot_seen[set_idx][way]  = r.arrival_time;
                end
                // promote the touched way to most recent
                old_rank = slot_rank[set_idx][way];
                for (int w = 0; w < NWAYS; w++) begin
                    if (slot_rank[set_idx][w] < old_rank)
                        slot_rank[set_idx][w]++;
                end
                slot_rank[set_idx][way] = 0;
                rsp.counted      = 1'b1;
                rsp.hit          = found;
                rsp.evicted      = evict;
                rsp.packet_total = slot_pkts[set_idx][way];
                rsp.byte_total   = slot_bytes[set_idx][way];
                n_counted++;
                n_hits   += found;
                n_evicts += evict;
            end
            owed_q.push_back(rsp);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %0h, expected %0h",
                                 n_checked, name, got, want));
        endtask

        task check_result(t_fctl_rsp got);
            t_fctl_rsp want;
            n_checked++;
            if (owed_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending: %h",
                                 n_checked, got));
            end else begin
                want = owed_q.pop_front();
                compare_field("counted", 64'(got.counted), 64'(want.counted));
                compare_field("hit", 64'(got.hit), 64'(want.hit));
                compare_field("evicted", 64'(got.evicted), 64'(want.evicted));
                compare_field("packet_total", got.packet_total, want.packet_total);
                compare_field("byte_total", got.byte_total, want.byte_total);
            end
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_fctl_req i_in_req;
    logic      o_out_valid;
    logic      i_out_stall;
    t_fctl_rsp o_out_rsp;

    flow_stats_board #(SET_COUNT, WAY_COUNT) board;

    logic [31:0] pool_key [HOT_SETS][POOL_DEPTH];
    bit          want_hold;
    int          holds_done;
    int          cycle_count;
    int          in_stall_cycles;

    flow_counter_table_lru #(
        .ENTRY_COUNT(ENTRY_COUNT),
        .WAYS       (WAY_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_rsp  (o_out_rsp)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid && o_in_stall === 1'b0)
                board.note_request(i_in_req);
            if (i_in_valid && o_in_stall === 1'b1)
                in_stall_cycles++;
            if (o_out_valid === 1'b1 && !i_out_stall)
                board.check_result(o_out_rsp);
        end
    end

    function automatic t_fctl_req make_request(logic [15:0] len, logic [15:0] etype,
                                               logic [31:0] addr, logic [63:0] stamp);
        t_fctl_req r;
        r.frame_length = len;
        r.ether_type   = etype;
        r.dest_addr    = addr;
        r.arrival_time = stamp;
        return r;
    endfunction

    function automatic logic [31:0] dir_key(int k);
        return 32'(k * SET_COUNT + DIR_SET);
    endfunction

    // Mostly counted frames aimed at a few crowded sets, so hits and
    // evictions both come up often; the rest is scattered or not counted.
    function automatic t_fctl_req random_request();
        t_fctl_req r;
        int        pick;
        int        hot;
        int        slot;
        pick           = $urandom_range(0, 99);
        hot            = $urandom_range(0, HOT_SETS - 1);
        slot           = $urandom_range(0, POOL_DEPTH - 1);
        r.arrival_time = {$urandom(), $urandom()};
        r.ether_type   = IPV4_TYPE;
        r.frame_length = 16'($urandom_range(MIN_COUNTED_LEN, 16'hFFFF));
        if (pick < 70)
            r.dest_addr = pool_key[hot][slot];
        else
            r.dest_addr = $urandom();
        if (pick >= 80 && pick < 90) begin
            r.frame_length = 16'($urandom_range(0, MIN_COUNTED_LEN - 1));
        end else if (pick >= 90) begin
            r.frame_length = 16'($urandom());
            r.ether_type   = $urandom_range(0, 1) ? 16'($urandom()) : ETH_IPV6;
        end
        return r;
    endfunction

    task automatic send_request(input t_fctl_req r);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    initial begin : result_sink
        int pct;
        int span;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (want_hold) begin
                want_hold = 1'b0;
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
            end else begin
                case ($urandom_range(0, 2))
                    0: pct = 0;
                    1: pct = 30;
                    default: pct = 75;
                endcase
                span = $urandom_range(1, 30);
                repeat (span) begin
                    @(negedge i_clk);
                    i_out_stall <= ($urandom_range(0, 99) < pct);
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed",
                 cycle_count, board.pending());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        t_fctl_req r;
        int        hot_set;
        int        burst;
        int        sent;
        bit        hold_asked;
        board           = new();
        want_hold       = 1'b0;
        holds_done      = 0;
        in_stall_cycles = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_req        = '0;

        for (int h = 0; h < HOT_SETS; h++) begin
            hot_set = (h == 0) ? DIR_SET : $urandom_range(0, SET_COUNT - 1);
            for (int k = 0; k < POOL_DEPTH; k++)
                pool_key[h][k] = (($urandom() / SET_COUNT) * SET_COUNT) + hot_set;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: length and type boundaries, full-range fields, then
        // fill one set and walk the LRU victim through it
        send_request(make_request(16'd33, IPV4_TYPE, 32'h0A00_0001, 64'd1));
        send_request(make_request(16'd34, ETH_ARP, 32'h0A00_0001, 64'd2));
        send_request(make_request(16'd0, 16'h0000, 32'd0, 64'd0));
        send_request(make_request(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '1));
        send_request(make_request(16'd34, IPV4_TYPE, 32'd0, 64'd0));
        send_request(make_request(16'hFFFF, IPV4_TYPE, 32'd0, '1));
        send_request(make_request(16'hFFFF, IPV4_TYPE, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000));
        send_request(make_request(16'd34, ETH_IPV6, 32'd0, 64'd5));
        send_request(make_request(16'd64, IPV4_TYPE, dir_key(1), 64'd10));
        send_request(make_request(16'd128, IPV4_TYPE, dir_key(2), 64'd11));
        send_request(make_request(16'd1500, IPV4_TYPE, dir_key(3), 64'd12));
        send_request(make_request(16'd9000, IPV4_TYPE, dir_key(4), 64'd13));
        send_request(make_request(16'd60, IPV4_TYPE, dir_key(1), 64'd14));
        send_request(make_request(16'd60, IPV4_TYPE, dir_key(5), 64'd15));
        send_request(make_request(16'd60, IPV4_TYPE, dir_key(2), 64'd16));
        send_request(make_request(16'd60, IPV4_TYPE, dir_key(4), 64'd17));
        send_request(make_request(16'd60, IPV4_TYPE, dir_key(6), 64'd18));
        send_request(make_request(16'd60, IPV4_TYPE, dir_key(1), 64'd19));
        send_request(make_request(16'd40, IPV4_TYPE, 32'd0, 64'd20));
        pause_sender(3);

        sent       = 0;
        hold_asked = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            // halfway through, keep offering while the result side holds off
            if (!hold_asked && sent >= RANDOM_ITEMS / 2) begin
                want_hold  = 1'b1;
                hold_asked = 1'b1;
                burst      = 60;
            end
            repeat (burst) begin
                r = random_request();
                sent++;
                send_request(r);
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d counted, %0d hits, %0d evictions; %0d results checked",
                 board.n_requests, board.n_counted, board.n_hits, board.n_evicts,
                 board.n_checked);
        $display("result side held off %0d time(s); request side stalled %0d cycles",
                 holds_done, in_stall_cycles);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results still owed", board.errors, board.pending());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/fctl_pkg.sv
rtl/core/fctl_set_index.sv
rtl/core/fctl_meta_store.sv
rtl/core/fctl_entry_store.sv
rtl/core/fctl_way_logic.sv
rtl/core/flow_counter_table_lru.sv
dv/tb_flow_counter_table_lru.sv
